@@ sv/quaternion_slerp_top_defines.svh @@
// Assertion macros shared by the quaternion slerp RTL.
// Used by the files that carry concurrent checks; depends on clk and arst_n in scope.
`ifndef QUATERNION_SLERP_TOP_DEFINES_SVH
`define QUATERNION_SLERP_TOP_DEFINES_SVH
// Same-cycle implication, disabled during reset
`define QS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ sv/qslerp_pkg.sv @@
// Shared types, constants and the CORDIC angle table for the quaternion slerp block.
// No dependencies; used by every module of the block.
package qslerp_pkg;

	localparam int CW      = 16;
	localparam int STEPS   = 16;
	localparam int QDEPTH  = 4;
	localparam int QAW     = 2;
	localparam int QCW     = 3;
	localparam int ROOT_STEPS = 31;
	localparam int DIV_STEPS  = 62;
	localparam int MAC_LAST   = 8;

	localparam logic [14:0] ONE14 = 15'd16384;
	localparam logic [30:0] ONE30 = 31'h4000_0000;

	// One classified item between front and back
	typedef struct packed {
		logic [3:0][15:0] a;
		logic [3:0][16:0] b;
		logic [14:0]      t;
		logic [13:0]      c;
		logic             trig;
	} qs_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_ATAN,
		ST_ANG1,
		ST_ANG0,
		ST_SIN,
		ST_DPREP,
		ST_DIV,
		ST_WGT,
		ST_MAC
	} back_state_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [30:0] atan_at(input logic [4:0] i);
		logic [30:0] v;
		case (i)
			5'd0:  v = 31'd843314856;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043836;
			5'd3:  v = 31'd133525158;
			5'd4:  v = 31'd67021686;
			5'd5:  v = 31'd33543515;
			5'd6:  v = 31'd16775850;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194282;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048575;
			5'd11: v = 31'd524287;
			5'd12: v = 31'd262143;
			5'd13: v = 31'd131071;
			5'd14: v = 31'd65535;
			5'd15: v = 31'd32767;
			5'd16: v = 31'd16383;
			5'd17: v = 31'd8191;
			5'd18: v = 31'd4095;
			5'd19: v = 31'd2047;
			5'd20: v = 31'd1023;
			5'd21: v = 31'd511;
			5'd22: v = 31'd255;
			5'd23: v = 31'd127;
			5'd24: v = 31'd63;
			5'd25: v = 31'd31;
			5'd26: v = 31'd15;
			5'd27: v = 31'd7;
			5'd28: v = 31'd3;
			5'd29: v = 31'd1;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/qslerp_front.sv @@
// Front end: clamps the blend, forms the rounded dot product and classifies the word.
// Depends on qslerp_pkg.
module qslerp_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic [3:0][15:0]         a_in,
	input  logic [3:0][15:0]         b_in,
	input  logic [15:0]              blend_in,
	input  logic [14:0]              thr,
	output logic                     item_valid,
	output qslerp_pkg::qs_item_t     item,
	output logic [1:0]               inflight
);

	logic                 valid_s1, valid_s2;
	logic [3:0][15:0]     a_s1;
	logic [3:0][15:0]     b_s1;
	logic [3:0][31:0]     p_s1;
	logic [14:0]          t_s1;
	qslerp_pkg::qs_item_t item_s2;

	logic [14:0]          t_clamp;
	logic signed [33:0]   psum;
	logic signed [19:0]   dot;
	logic signed [20:0]   dot_abs;
	logic signed [21:0]   diff;
	logic                 neg;
	qslerp_pkg::qs_item_t item_d;

	// clamp blend to [0, one]
	always_comb begin
		if (blend_in[15]) begin
			t_clamp = '0;
		end else if (blend_in[14:0] > qslerp_pkg::ONE14) begin
			t_clamp = qslerp_pkg::ONE14;
		end else begin
			t_clamp = blend_in[14:0];
		end
	end

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_in;
		b_s1 <= b_in;
		t_s1 <= t_clamp;
		for (int k = 0; k < 4; k++) begin
			p_s1[k] <= 32'($signed(a_in[k]) * $signed(b_in[k]));
		end
	end

	// dot, sign fold and path choice
	always_comb begin
		psum = '0;
		for (int k = 0; k < 4; k++) begin
			psum = psum + 34'($signed(p_s1[k]));
		end
		dot     = 20'((psum + 34'sd8192) >>> 14);
		neg     = dot[19];
		dot_abs = neg ? -21'(dot) : 21'(dot);
		diff    = 22'sd16384 - 22'(dot_abs);
		item_d.a    = a_s1;
		item_d.t    = t_s1;
		item_d.c    = dot_abs[13:0];
		item_d.trig = diff > $signed({7'b0, thr});
		for (int k = 0; k < 4; k++) begin
			item_d.b[k] = neg ? -{b_s1[k][15], b_s1[k]} : {b_s1[k][15], b_s1[k]};
		end
	end

	// stage 2: classified word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_d;
	end

	assign item_valid = valid_s2;
	assign item       = item_s2;
	assign inflight   = {1'b0, valid_s1} + {1'b0, valid_s2};

endmodule

@@ sv/qslerp_fifo.sv @@
// Short queue of classified words between the front and back ends.
// Depends on qslerp_pkg and quaternion_slerp_top_defines.svh.
`include "quaternion_slerp_top_defines.svh"
module qslerp_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  qslerp_pkg::qs_item_t            wdata,
	input  logic                            pop,
	output qslerp_pkg::qs_item_t            rdata,
	output logic                            not_empty,
	output logic [qslerp_pkg::QCW-1:0]      count
);

	localparam int QCW = qslerp_pkg::QCW;

	qslerp_pkg::qs_item_t            mem_q [qslerp_pkg::QDEPTH];
	logic [qslerp_pkg::QAW-1:0]      wr_q, rd_q;
	logic [qslerp_pkg::QCW-1:0]      cnt_q;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign rdata     = mem_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign count     = cnt_q;

	`QS_ASSERT_NOW(a_no_overflow, push && !pop, cnt_q != QCW'(qslerp_pkg::QDEPTH), "queue overflow")
	`QS_ASSERT_NOW(a_no_underflow, pop, cnt_q != '0, "queue underflow")

endmodule

@@ sv/qslerp_back.sv @@
// Back end: sqrt, CORDIC atan2 and sines, weight division and the final blend.
// Depends on qslerp_pkg and quaternion_slerp_top_defines.svh.
`include "quaternion_slerp_top_defines.svh"
module qslerp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  qslerp_pkg::qs_item_t    in_item,
	output logic                    in_pop,
	output logic                    done,
	output logic [3:0][15:0]        res,
	output logic                    lin
);

	qslerp_pkg::back_state_t state_q, state_d;

	qslerp_pkg::qs_item_t  item_q;
	logic [5:0]            cnt_q;
	logic [61:0]           rad_q;
	logic [32:0]           rem_q;
	logic [30:0]           root_q;
	logic signed [33:0]    ax_q, ay_q;
	logic signed [32:0]    az_q;
	logic [30:0]           om_q;
	logic signed [33:0]    sx_q [3];
	logic signed [33:0]    sy_q [3];
	logic signed [32:0]    sz_q [3];
	logic [61:0]           num_q [2];
	logic [61:0]           quo_q [2];
	logic [31:0]           drem_q [2];
	logic                  spos_q [2];
	logic [30:0]           dvs_q;
	logic [30:0]           w0_q, w1_q;
	logic signed [48:0]    prod_q, acc_q;
	logic [3:0][15:0]      res_q;
	logic                  lin_q, done_q;

	logic [4:0]            idx;
	logic signed [32:0]    ang;
	logic [30:0]           t30, t30_in;
	logic [29:0]           c30;
	logic [34:0]           rem_sh, trial;
	logic                  ge;
	logic [30:0]           root_nx;
	logic [32:0]           rem_nx;
	logic                  last_step;
	logic                  cnt_clr;

	assign idx    = cnt_q[4:0];
	assign ang    = 33'(qslerp_pkg::atan_at(idx));
	assign t30    = {item_q.t, 16'b0};
	assign t30_in = {in_item.t, 16'b0};
	assign c30    = {item_q.c, 16'b0};

	// one square root digit
	always_comb begin
		rem_sh  = {rem_q, rad_q[61:60]};
		trial   = {2'b0, root_q, 2'b01};
		ge      = rem_sh >= trial;
		root_nx = {root_q[29:0], ge};
		rem_nx  = ge ? 33'(rem_sh - trial) : rem_sh[32:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qslerp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_pop    = 1'b0;
		last_step = 1'b0;
		cnt_clr   = 1'b0;
		case (state_q)
			qslerp_pkg::ST_IDLE: begin
				cnt_clr = 1'b1;
				if (in_valid) begin
					in_pop  = 1'b1;
					state_d = in_item.trig ? qslerp_pkg::ST_SQ : qslerp_pkg::ST_MAC;
				end
			end
			qslerp_pkg::ST_SQ: begin
				cnt_clr = 1'b1;
				state_d = qslerp_pkg::ST_ROOT;
			end
			qslerp_pkg::ST_ROOT: begin
				last_step = cnt_q == 6'(qslerp_pkg::ROOT_STEPS - 1);
				if (last_step) state_d = qslerp_pkg::ST_ATAN;
			end
			qslerp_pkg::ST_ATAN: begin
				last_step = cnt_q == 6'(qslerp_pkg::STEPS - 1);
				if (last_step) state_d = qslerp_pkg::ST_ANG1;
			end
			qslerp_pkg::ST_ANG1: state_d = qslerp_pkg::ST_ANG0;
			qslerp_pkg::ST_ANG0: begin
				cnt_clr = 1'b1;
				state_d = qslerp_pkg::ST_SIN;
			end
			qslerp_pkg::ST_SIN: begin
				last_step = cnt_q == 6'(qslerp_pkg::STEPS - 1);
				if (last_step) state_d = qslerp_pkg::ST_DPREP;
			end
			qslerp_pkg::ST_DPREP: begin
				cnt_clr = 1'b1;
				state_d = (sy_q[0] > 34'sd0) ? qslerp_pkg::ST_DIV : qslerp_pkg::ST_MAC;
			end
			qslerp_pkg::ST_DIV: begin
				last_step = cnt_q == 6'(qslerp_pkg::DIV_STEPS - 1);
				if (last_step) state_d = qslerp_pkg::ST_WGT;
			end
			qslerp_pkg::ST_WGT: begin
				cnt_clr = 1'b1;
				state_d = qslerp_pkg::ST_MAC;
			end
			qslerp_pkg::ST_MAC: begin
				last_step = cnt_q == 6'(qslerp_pkg::MAC_LAST);
				if (last_step) state_d = qslerp_pkg::ST_IDLE;
			end
			default: begin
				cnt_clr = 1'b1;
				state_d = qslerp_pkg::ST_IDLE;
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == qslerp_pkg::ST_MAC) && last_step;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic [61:0]        mprod;
		logic [30:0]        om;
		logic [32:0]        dsh;
		logic [30:0]        q;
		logic [2:0]         j;
		logic signed [49:0] vsum;
		logic signed [19:0] r;
		cnt_q <= (last_step || cnt_clr) ? 6'd0 : cnt_q + 6'd1;
		case (state_q)
			qslerp_pkg::ST_IDLE: begin
				item_q <= in_item;
				w0_q   <= qslerp_pkg::ONE30 - t30_in;
				w1_q   <= t30_in;
				lin_q  <= 1'b1;
			end
			qslerp_pkg::ST_SQ: begin
				mprod  = 62'(c30 * c30);
				rad_q  <= (62'd1 << 60) - mprod;
				rem_q  <= '0;
				root_q <= '0;
			end
			qslerp_pkg::ST_ROOT: begin
				rad_q  <= {rad_q[59:0], 2'b00};
				rem_q  <= rem_nx;
				root_q <= root_nx;
				ax_q   <= 34'(c30);
				ay_q   <= 34'(root_nx);
				az_q   <= '0;
			end
			qslerp_pkg::ST_ATAN: begin
				if (ay_q > 34'sd0) begin
					ax_q <= ax_q + (ay_q >>> idx);
					ay_q <= ay_q - (ax_q >>> idx);
					az_q <= az_q + ang;
				end else begin
					ax_q <= ax_q - (ay_q >>> idx);
					ay_q <= ay_q + (ax_q >>> idx);
					az_q <= az_q - ang;
				end
			end
			qslerp_pkg::ST_ANG1: begin
				om      = az_q[32] ? 31'd0 : az_q[30:0];
				om_q    <= om;
				mprod   = t30 * om;
				sz_q[2] <= 33'(mprod[61:30]);
			end
			qslerp_pkg::ST_ANG0: begin
				mprod   = (qslerp_pkg::ONE30 - t30) * om_q;
				sz_q[1] <= 33'(mprod[61:30]);
				sz_q[0] <= 33'(om_q);
				for (int l = 0; l < 3; l++) begin
					sx_q[l] <= 34'(qslerp_pkg::ONE30);
					sy_q[l] <= '0;
				end
			end
			qslerp_pkg::ST_SIN: begin
				for (int l = 0; l < 3; l++) begin
					if (!sz_q[l][32]) begin
						sx_q[l] <= sx_q[l] - (sy_q[l] >>> idx);
						sy_q[l] <= sy_q[l] + (sx_q[l] >>> idx);
						sz_q[l] <= sz_q[l] - ang;
					end else begin
						sx_q[l] <= sx_q[l] + (sy_q[l] >>> idx);
						sy_q[l] <= sy_q[l] - (sx_q[l] >>> idx);
						sz_q[l] <= sz_q[l] + ang;
					end
				end
			end
			qslerp_pkg::ST_DPREP: begin
				dvs_q <= sy_q[0][30:0];
				lin_q <= !(sy_q[0] > 34'sd0);
				for (int l = 0; l < 2; l++) begin
					spos_q[l] <= sy_q[l+1] > 34'sd0;
					num_q[l]  <= {1'b0, sy_q[l+1][30:0], 30'b0} + {32'b0, sy_q[0][30:1]};
					quo_q[l]  <= '0;
					drem_q[l] <= '0;
				end
			end
			qslerp_pkg::ST_DIV: begin
				for (int l = 0; l < 2; l++) begin
					dsh = {drem_q[l], num_q[l][61]};
					num_q[l] <= {num_q[l][60:0], 1'b0};
					if (dsh >= {2'b0, dvs_q}) begin
						drem_q[l] <= 32'(dsh - {2'b0, dvs_q});
						quo_q[l]  <= {quo_q[l][60:0], 1'b1};
					end else begin
						drem_q[l] <= dsh[31:0];
						quo_q[l]  <= {quo_q[l][60:0], 1'b0};
					end
				end
			end
			qslerp_pkg::ST_WGT: begin
				// clamp each weight to [0, one]
				for (int l = 0; l < 2; l++) begin
					if (!spos_q[l]) begin
						q = '0;
					end else if ((|quo_q[l][61:31]) || (quo_q[l][30:0] > qslerp_pkg::ONE30)) begin
						q = qslerp_pkg::ONE30;
					end else begin
						q = quo_q[l][30:0];
					end
					if (l == 0) begin
						w0_q <= q;
					end else begin
						w1_q <= q;
					end
				end
			end
			qslerp_pkg::ST_MAC: begin
				// one product per cycle, accumulate one behind
				if (cnt_q[0]) begin
					prod_q <= 49'($signed({1'b0, w1_q}) * $signed(item_q.b[cnt_q[2:1]]));
				end else begin
					prod_q <= 49'($signed({1'b0, w0_q}) *
						$signed({item_q.a[cnt_q[2:1]][15], item_q.a[cnt_q[2:1]]}));
				end
				if (cnt_q != 6'd0) begin
					j = cnt_q[2:0] - 3'd1;
					if (!j[0]) begin
						acc_q <= prod_q;
					end else begin
						vsum = 50'(acc_q) + 50'(prod_q) + (50'sd1 <<< 29);
						r    = 20'(vsum >>> 30);
						if (r > 20'sd32767) begin
							res_q[j[2:1]] <= 16'h7fff;
						end else if (r < -20'sd32768) begin
							res_q[j[2:1]] <= 16'h8000;
						end else begin
							res_q[j[2:1]] <= r[15:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;
	assign lin  = lin_q;

	`QS_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")
	`QS_ASSERT_NEXT(a_pop_leaves_idle, in_pop, state_q != qslerp_pkg::ST_IDLE,
		"word taken but sequencer stayed idle")

endmodule

@@ sv/quaternion_slerp_top.sv @@
// Quaternion slerp top level: a front end that classifies each word, a short queue,
// and an iterative back end. Depends on qslerp_pkg, qslerp_front, qslerp_fifo, qslerp_back.
//
// Each accepted pair of quaternions yields one result word on done, held one cycle;
// the receiver cannot stall. start is taken whenever busy is low, so words enter back to
// back until four words sit in the two front stages and the four-entry queue together;
// busy then holds start off. The back end works one word at a time and its sequence sets
// the steady rate: a linear blend takes a pick-up step and the multiply-accumulate pass;
// a spherical blend takes pick-up, squaring, 31 square-root
// steps, 16 atan2 steps, two angle products, 16 sine steps on three lanes, divide setup,
// 62 division steps on two lanes, weight clamp and the multiply-accumulate pass.
// On an idle block a word passes the two front stages and the queue before the back end
// picks it up. Results leave in input order. The threshold register thr_q is written
// through cfg_wr_en/cfg_wr_data.
module quaternion_slerp_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] from_x,
	input  logic [15:0] from_y,
	input  logic [15:0] from_z,
	input  logic [15:0] from_w,
	input  logic [15:0] target_x,
	input  logic [15:0] target_y,
	input  logic [15:0] target_z,
	input  logic [15:0] target_w,
	input  logic [15:0] blend,
	input  logic        cfg_wr_en,
	input  logic [14:0] cfg_wr_data,
	output logic        done,
	output logic [15:0] out_x,
	output logic [15:0] out_y,
	output logic [15:0] out_z,
	output logic [15:0] out_w,
	output logic        linear_used
);

	logic [14:0]                     thr_q;
	logic                            take;
	logic                            f_valid;
	qslerp_pkg::qs_item_t            f_item, q_item;
	logic [1:0]                      inflight;
	logic                            q_ne, q_pop;
	logic [qslerp_pkg::QCW-1:0]      q_cnt;
	logic [3:0][15:0]                res;

	// hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 15'd1;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// stall when queue plus front stages would overfill
	assign busy = ({1'b0, q_cnt} + 4'(inflight)) >= 4'(qslerp_pkg::QDEPTH);
	assign take = start && !busy;

	qslerp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.a_in       ({from_w, from_z, from_y, from_x}),
		.b_in       ({target_w, target_z, target_y, target_x}),
		.blend_in   (blend),
		.thr        (thr_q),
		.item_valid (f_valid),
		.item       (f_item),
		.inflight   (inflight)
	);

	qslerp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.wdata     (f_item),
		.pop       (q_pop),
		.rdata     (q_item),
		.not_empty (q_ne),
		.count     (q_cnt)
	);

	qslerp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_ne),
		.in_item  (q_item),
		.in_pop   (q_pop),
		.done     (done),
		.res      (res),
		.lin      (linear_used)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];
	assign out_w = res[3];

endmodule

@@ bench/quaternion_slerp_top_tb.sv @@
// Self-checking bench for quaternion_slerp_top: drives pairs of quaternions,
// predicts each output word with a bit-exact fixed-point slerp model.
// Depends only on the quaternion_slerp_top RTL.
`timescale 1ns / 100ps

module quaternion_slerp_top_tb;

	localparam int  LIMIT_CYCLES = 3000000;
	localparam longint ATAN_TAB [16] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
		65535, 32767};

	typedef struct {
		logic [3:0][15:0] q;
		logic             lin;
	} slerp_word_t;

	// Expected output words and the slerp arithmetic that produces them
	class slerp_scoreboard;
		slerp_word_t expected_q[$];
		longint      thr = 1;
		int          mismatches = 0;
		int          failures = 0;

		function longint vec_atan2(longint y, longint x);
			longint z, xs, ys;
			z = 0;
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += ATAN_TAB[i];
				end else begin
					x -= ys; y += xs; z -= ATAN_TAB[i];
				end
			end
			return z;
		endfunction

		function longint rot_sin(longint z);
			longint x, y, xs, ys;
			x = 64'sd1 << 30;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= ATAN_TAB[i];
				end else begin
					x += ys; y -= xs; z += ATAN_TAB[i];
				end
			end
			return y;
		endfunction

		function longint root(longint unsigned v);
			longint unsigned r, bt;
			r = 0;
			bt = 64'd1 << 62;
			while (bt > v) bt >>= 2;
			while (bt != 0) begin
				if (v >= r + bt) begin
					v -= r + bt;
					r = (r >> 1) + bt;
				end else
					r >>= 1;
				bt >>= 2;
			end
			return longint'(r);
		endfunction

		function longint ratio(longint s, longint sn);
			longint q;
			if (s <= 0)
				return 0;
			q = (s * (64'sd1 << 30) + sn / 2) / sn;
			return (q > (64'sd1 << 30)) ? (64'sd1 << 30) : q;
		endfunction

		// Predict the word for one accepted pair and queue it
		function void note(logic [3:0][15:0] fa, logic [3:0][15:0] tb_in, logic [15:0] tin);
			longint a[4], b[4], t, t30, p, hi, lo, dot, s0, s1, c30, s30, om, sn, v, r;
			longint unsigned c2;
			slerp_word_t e;
			hi = 0;
			lo = 0;
			e.lin = 1'b1;
			for (int k = 0; k < 4; k++) begin
				a[k] = longint'($signed(fa[k]));
				b[k] = longint'($signed(tb_in[k]));
			end
			t = longint'($signed(tin));
			if (t < 0) t = 0;
			if (t > 16384) t = 16384;
			t30 = t << 16;
			for (int k = 0; k < 4; k++) begin
				p = a[k] * b[k];
				hi += p >>> 14;
				lo += p & 64'sd16383;
			end
			dot = hi + ((lo + 8192) >>> 14);
			if (dot < 0) begin
				dot = -dot;
				for (int k = 0; k < 4; k++) b[k] = -b[k];
			end
			s0 = (64'sd1 << 30) - t30;
			s1 = t30;
			if (16384 - dot > thr) begin
				c30 = dot << 16;
				c2 = longint'(c30) * longint'(c30);
				s30 = root((64'd1 << 60) - c2);
				om = vec_atan2(s30, c30);
				if (om < 0) om = 0;
				sn = rot_sin(om);
				if (sn > 0) begin
					s0 = ratio(rot_sin((((64'sd1 << 30) - t30) * om) >>> 30), sn);
					s1 = ratio(rot_sin((t30 * om) >>> 30), sn);
					e.lin = 1'b0;
				end
			end
			for (int k = 0; k < 4; k++) begin
				v = s0 * a[k] + s1 * b[k];
				r = (v + (64'sd1 << 29)) >>> 30;
				if (r > 32767) r = 32767;
				if (r < -32768) r = -32768;
				e.q[k] = r[15:0];
			end
			expected_q.push_back(e);
		endfunction

		// Compare one output word with the oldest prediction
		function void check(logic [3:0][15:0] got, logic lin);
			slerp_word_t e;
			if (expected_q.size() == 0) begin
				failures++;
				if (mismatches++ < 10)
					$display("unexpected word: out=%h lin=%b", got, lin);
				return;
			end
			e = expected_q.pop_front();
			if (e.q !== got || e.lin !== lin) begin
				failures++;
				if (mismatches++ < 10)
					$display("mismatch: expected out=%h lin=%b, got out=%h lin=%b",
						e.q, e.lin, got, lin);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0][15:0] from_q = '0;
	logic [3:0][15:0] target_q = '0;
	logic [15:0] blend = '0;
	logic        cfg_wr_en = 1'b0;
	logic [14:0] cfg_wr_data = '0;
	logic        done;
	logic [3:0][15:0] out_q;
	logic        linear_used;
	int          cycles = 0;
	slerp_scoreboard sb = new();

	always #1 clk = ~clk;

	quaternion_slerp_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.from_x(from_q[0]), .from_y(from_q[1]), .from_z(from_q[2]), .from_w(from_q[3]),
		.target_x(target_q[0]), .target_y(target_q[1]),
		.target_z(target_q[2]), .target_w(target_q[3]),
		.blend(blend), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.done(done), .out_x(out_q[0]), .out_y(out_q[1]), .out_z(out_q[2]),
		.out_w(out_q[3]), .linear_used(linear_used)
	);

	// Watch both handshakes and the cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("[quaternion_slerp_top] ERROR");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy)
				sb.note(from_q, target_q, blend);
			if (done)
				sb.check(out_q, linear_used);
		end
	end

	// Present one word and hold it until taken
	task automatic send_word(logic [3:0][15:0] fq, logic [3:0][15:0] tq, logic [15:0] bl);
		start <= 1'b1;
		from_q <= fq;
		target_q <= tq;
		blend <= bl;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop start and wait until every predicted word has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [14:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.thr = longint'(v);
		@(posedge clk);
	endtask

	function automatic logic [3:0][15:0] unit_quat();
		real v[4], n;
		logic [3:0][15:0] q;
		n = 0.0;
		for (int k = 0; k < 4; k++) begin
			v[k] = real'($urandom_range(20000)) - 10000.0;
			n += v[k] * v[k];
		end
		if (n < 1.0) begin
			v[3] = 1.0;
			n = 1.0;
		end
		n = $sqrt(n);
		for (int k = 0; k < 4; k++)
			q[k] = 16'($rtoi(v[k] / n * 16384.0));
		return q;
	endfunction

	function automatic logic [15:0] pick_blend();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'd0;
			2: return 16'd16384;
			default: return 16'($urandom_range(16384));
		endcase
	endfunction

	// One random word: mostly unit pairs, some near-parallel pairs, some raw noise
	task automatic random_word(bit gaps);
		logic [3:0][15:0] fq, tq;
		int sel;
		sel = $urandom_range(9);
		fq = unit_quat();
		if (sel < 6)
			tq = unit_quat();
		else if (sel < 8) begin
			for (int k = 0; k < 4; k++)
				tq[k] = fq[k] + 16'($urandom_range(40)) - 16'd20;
			if ($urandom_range(1))
				for (int k = 0; k < 4; k++) tq[k] = -tq[k];
		end else begin
			for (int k = 0; k < 4; k++) begin
				fq[k] = 16'($urandom);
				tq[k] = 16'($urandom);
			end
		end
		if (gaps && $urandom_range(3) == 0)
			pause($urandom_range(1, 4));
		send_word(fq, tq, pick_blend());
	endtask

	initial begin
		logic [3:0][15:0] u, v;
		logic [14:0] thr_list [5];
		thr_list = '{15'd0, 15'd16384, 15'd40, 15'd0, 15'd1};
		thr_list[3] = 15'($urandom_range(16384));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, clamp, zero and negative dot, non-unit, identical
		send_word({4{16'h8000}}, {4{16'h8000}}, 16'h8000);
		send_word({4{16'h7fff}}, {4{16'h7fff}}, 16'h7fff);
		send_word({4{16'h7fff}}, {4{16'h8000}}, 16'd8192);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd16384, 16'd0},
			16'd8192);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd0, 16'hc000},
			16'd4000);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'h8000, 16'h8000},
			16'd100);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd0, 16'd16384},
			16'd9000);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd11585, 16'd11585},
			16'hffff);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd11585, 16'd11585},
			16'd16385);
		for (int i = 0; i < 8; i++) begin
			u = unit_quat();
			v = unit_quat();
			send_word(u, v, pick_blend());
		end
		drain();
		write_threshold(15'd0);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd1, 16'd16384},
			16'd8192);
		send_word({16'd0, 16'd0, 16'd0, 16'd16384}, {16'd0, 16'd0, 16'd180, 16'd16383},
			16'd5000);
		drain();

		// Random phases, one threshold each; the last one runs without gaps
		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_list[ph]);
			for (int i = 0; i < 180; i++)
				random_word(ph != 4);
			drain();
		end

		if (sb.failures == 0 && sb.expected_q.size() == 0)
			$display("[quaternion_slerp_top] OK");
		else
			$display("[quaternion_slerp_top] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/qslerp_pkg.sv
sv/qslerp_front.sv
sv/qslerp_fifo.sv
sv/qslerp_back.sv
sv/quaternion_slerp_top.sv
bench/quaternion_slerp_top_tb.sv
